>>> sv/pcm_pkg.sv
package pcm_pkg;

    // One buffered point as it arrived.
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] tag;
        logic        lin;
    } t_entry;

    // Point projected onto the working plane.
    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_uv;

    // One kept point on the output side.
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        path_end;
        logic        run_end;
    } t_kept;

    // Per-item line data broadcast to the distance checker.
    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] au;
        logic signed [31:0] av;
        logic signed [32:0] su;
        logic signed [32:0] sv;
        logic               zero;
        logic [61:0]        tol2;
        logic [128:0]       thr;
    } t_chk_ref;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AXIS   = 2'd0;
    localparam logic [1:0] CFG_TOL    = 2'd1;
    localparam logic [1:0] CFG_MAXLEN = 2'd2;

    // Dropped-axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // Cycles spent draining the five-stage checker pipeline after the scan.
    localparam int DRAIN_CYC = 6;

    // Output queue depth.
    localparam int OQ_DEPTH = 4;

    function automatic t_uv proj(input logic [1:0] axis, input t_entry e);
        t_uv r;
        case (axis)
            AXIS_X:  begin r.u = e.y; r.v = e.z; end
            AXIS_Y:  begin r.u = e.x; r.v = e.z; end
            default: begin r.u = e.x; r.v = e.y; end
        endcase
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        logic [32:0] r;
        r = d[32] ? 33'(-d) : 33'(d);
        return r;
    endfunction

endpackage

>>> sv/pcm_in_if.sv
interface pcm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic        is_linear;
    logic [15:0] tag;
    logic        path_last;

    modport source(output valid, coord_x, coord_y, coord_z, is_linear, tag, path_last,
                   input ready);
    modport sink(input valid, coord_x, coord_y, coord_z, is_linear, tag, path_last,
                 output ready);
endinterface

>>> sv/pcm_out_if.sv
interface pcm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] kept_tag;
    logic [31:0] kept_x;
    logic [31:0] kept_y;
    logic [31:0] kept_z;
    logic        path_end;
    logic        run_end;

    modport source(output valid, kept_tag, kept_x, kept_y, kept_z, path_end, run_end,
                   input ready);
    modport sink(input valid, kept_tag, kept_x, kept_y, kept_z, path_end, run_end,
                 output ready);
endinterface

>>> sv/pcm_cell.sv
module pcm_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_shift,
    input  pcm_pkg::t_entry i_load_ent,
    input  pcm_pkg::t_entry i_next,
    output pcm_pkg::t_entry o_ent
);

    pcm_pkg::t_entry r_ent;

    // A cell either takes a new point or the point of its neighbor.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_load_ent;
        end else if (i_shift) begin
            r_ent <= i_next;
        end
    end

    assign o_ent = r_ent;

endmodule

>>> sv/pcm_check.sv
module pcm_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  pcm_pkg::t_entry   i_ent,
    input  pcm_pkg::t_chk_ref i_ref,
    output logic              o_vld,
    output logic              o_bad
);

    logic [4:0] r_vld;

    logic signed [32:0] r_du, r_dv;
    logic               r_lin0;
    logic [65:0]        r_am, r_bm;
    logic               r_an, r_bn, r_lin1;
    logic [66:0]        r_cm2, r_cm3;
    logic               r_lin2, r_lin3;
    logic [65:0]        r_hh;
    logic [66:0]        r_hl;
    logic [67:0]        r_ll;
    logic               r_bad;

    pcm_pkg::t_uv w_p;
    logic [32:0]  w_m1, w_m2, w_m3, w_m4;
    logic [66:0]  w_sum, w_dif;
    logic [133:0] w_sq;

    // Valid travels alongside the point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // Stage 0: project and take the offset from the anchor.
    assign w_p = pcm_pkg::proj(i_ref.axis, i_ent);
    always_ff @(posedge i_clk) begin
        r_du   <= {w_p.u[31], w_p.u} - {i_ref.au[31], i_ref.au};
        r_dv   <= {w_p.v[31], w_p.v} - {i_ref.av[31], i_ref.av};
        r_lin0 <= i_ent.lin;
    end

    // Stage 1: magnitudes of the cross terms, or of the squares for a point line.
    assign w_m1 = pcm_pkg::mag33(r_du);
    assign w_m2 = i_ref.zero ? pcm_pkg::mag33(r_du) : pcm_pkg::mag33(i_ref.sv);
    assign w_m3 = pcm_pkg::mag33(r_dv);
    assign w_m4 = i_ref.zero ? pcm_pkg::mag33(r_dv) : pcm_pkg::mag33(i_ref.su);
    always_ff @(posedge i_clk) begin
        r_am   <= w_m1 * w_m2;
        r_bm   <= w_m3 * w_m4;
        r_an   <= r_du[32] ^ i_ref.sv[32];
        r_bn   <= r_dv[32] ^ i_ref.su[32];
        r_lin1 <= r_lin0;
    end

    // Stage 2: magnitude of the cross product, or the squared distance for a point line.
    assign w_sum = 67'(r_am) + 67'(r_bm);
    assign w_dif = (r_am >= r_bm) ? 67'(r_am - r_bm) : 67'(r_bm - r_am);
    always_ff @(posedge i_clk) begin
        r_cm2  <= (i_ref.zero || (r_an != r_bn)) ? w_sum : w_dif;
        r_lin2 <= r_lin1;
    end

    // Stage 3: partial products of the squared cross product.
    always_ff @(posedge i_clk) begin
        r_hh   <= r_cm2[66:34] * r_cm2[66:34];
        r_hl   <= r_cm2[66:34] * r_cm2[33:0];
        r_ll   <= r_cm2[33:0] * r_cm2[33:0];
        r_cm3  <= r_cm2;
        r_lin3 <= r_lin2;
    end

    // Stage 4: sum the partials and compare against the threshold.
    assign w_sq = (134'(r_hh) << 68) + (134'(r_hl) << 35) + 134'(r_ll);
    always_ff @(posedge i_clk) begin
        r_bad <= !r_lin3 || (i_ref.zero ? (r_cm3 > 67'(i_ref.tol2))
                                        : (w_sq > 134'(i_ref.thr)));
    end

    assign o_vld = r_vld[4];
    assign o_bad = r_bad;

endmodule

>>> sv/polyline_collinear_merger_top.sv
// Polyline merger: takes tool-path points, projects them onto the configured
// plane and keeps only the endpoints of merged lines. The first point of a path
// sets the anchor. Every later point goes through acceptance, a setup of the
// candidate line in states S_P0 to S_P4, one full turn of the ring of WINDOW
// buffer cells through the distance checker (one held point a cycle), a drain of
// the checker pipeline and an update of the buffer.
// Up to two kept points per input word wait in a four-word output queue, and a
// new point is taken while idle with at least two queue slots free.
module polyline_collinear_merger_top #(
    parameter int WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    pcm_in_if.sink      i_pt,
    pcm_out_if.source   o_kept
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = $clog2(WINDOW);
    localparam int QW = $clog2(pcm_pkg::OQ_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_P0    = 9'b000000010,
        S_P1    = 9'b000000100,
        S_P2    = 9'b000001000,
        S_P3    = 9'b000010000,
        S_P4    = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_DRAIN = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state;

    // Configuration.
    logic [1:0]  r_axis;
    logic [30:0] r_tol;
    logic [30:0] r_maxlen;

    // Path state.
    logic signed [31:0] r_au, r_av;
    logic               r_have;
    logic [CW-1:0]      r_cnt;
    pcm_pkg::t_entry    r_cand;

    // Current item and its line.
    pcm_pkg::t_entry    r_in;
    logic               r_last;
    logic signed [31:0] r_pu, r_pv;
    logic signed [32:0] r_su, r_sv;
    logic               r_zero;
    logic [65:0]        r_squ, r_sqv;
    logic [61:0]        r_tol2, r_lim2;
    logic [66:0]        r_len2;
    logic               r_acc0;
    logic [64:0]        r_p_hh, r_p_lh;
    logic [63:0]        r_p_hl, r_p_ll;
    logic [128:0]       r_thr;
    logic               r_bad;
    logic [SW-1:0]      r_scan;
    logic [2:0]         r_drn;

    // Output queue.
    pcm_pkg::t_kept     r_oq [pcm_pkg::OQ_DEPTH];
    logic [QW-1:0]      r_wp, r_rp;
    logic [QW:0]        r_ocnt;

    pcm_pkg::t_entry    w_pt;
    pcm_pkg::t_uv       w_ppt, w_pcand;
    logic               w_in_acc, w_out_acc;
    pcm_pkg::t_entry    w_ent [WINDOW];
    logic [WINDOW-1:0]  w_load;
    logic               w_shift;
    logic               w_acc;
    logic               w_fin;
    pcm_pkg::t_chk_ref  w_ref;
    logic               w_chk_vld, w_chk_bad;
    pcm_pkg::t_kept     w_res_a, w_res_b;
    logic [1:0]         w_nres;

    // Input word and handshakes.
    assign w_pt.x   = i_pt.coord_x;
    assign w_pt.y   = i_pt.coord_y;
    assign w_pt.z   = i_pt.coord_z;
    assign w_pt.tag = i_pt.tag;
    assign w_pt.lin = i_pt.is_linear;
    assign w_ppt    = pcm_pkg::proj(r_axis, w_pt);
    assign w_pcand  = pcm_pkg::proj(r_axis, r_cand);

    assign i_pt.ready = (r_state == S_IDLE) && (r_ocnt <= (QW + 1)'(pcm_pkg::OQ_DEPTH - 2));
    assign w_in_acc   = i_pt.valid && i_pt.ready;
    assign w_out_acc  = o_kept.valid && o_kept.ready;
    assign w_fin      = (r_state == S_FIN);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= 2'd2;
            r_tol    <= 31'd655;
            r_maxlen <= 31'h7FFFFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcm_pkg::CFG_AXIS:   r_axis   <= i_cfg_data[1:0];
                pcm_pkg::CFG_TOL:    r_tol    <= i_cfg_data;
                pcm_pkg::CFG_MAXLEN: r_maxlen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ring of buffer cells; cell 0 feeds the checker.
    assign w_shift = (r_state == S_SCAN);
    generate
        for (genvar i = 0; i < WINDOW; i++) begin : g_cell
            assign w_load[i] = w_fin && (w_acc ? (r_cnt == CW'(i)) : (i == 0));
            pcm_cell u_cell (
                .i_clk      (i_clk),
                .i_load     (w_load[i]),
                .i_shift    (w_shift),
                .i_load_ent (r_in),
                .i_next     (w_ent[(i + 1) % WINDOW]),
                .o_ent      (w_ent[i])
            );
        end
    endgenerate

    // Distance checker.
    assign w_ref.axis = r_axis;
    assign w_ref.au   = r_au;
    assign w_ref.av   = r_av;
    assign w_ref.su   = r_su;
    assign w_ref.sv   = r_sv;
    assign w_ref.zero = r_zero;
    assign w_ref.tol2 = r_tol2;
    assign w_ref.thr  = r_thr;

    pcm_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_shift && (CW'(r_scan) < r_cnt)),
        .i_ent   (w_ent[0]),
        .i_ref   (w_ref),
        .o_vld   (w_chk_vld),
        .o_bad   (w_chk_bad)
    );

    // Decision for the current item.
    assign w_acc = (r_cnt == '0)
                || ((r_cnt != CW'(WINDOW)) && r_acc0 && !r_bad);

    // Line setup arithmetic.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in   <= w_pt;
            r_last <= i_pt.path_last;
            r_pu   <= w_ppt.u;
            r_pv   <= w_ppt.v;
        end
        if (r_state == S_P0) begin
            r_su   <= {r_pu[31], r_pu} - {r_au[31], r_au};
            r_sv   <= {r_pv[31], r_pv} - {r_av[31], r_av};
            r_zero <= (r_pu == r_au) && (r_pv == r_av);
        end
        if (r_state == S_P1) begin
            r_squ  <= pcm_pkg::mag33(r_su) * pcm_pkg::mag33(r_su);
            r_sqv  <= pcm_pkg::mag33(r_sv) * pcm_pkg::mag33(r_sv);
            r_tol2 <= r_tol * r_tol;
            r_lim2 <= r_maxlen * r_maxlen;
        end
        if (r_state == S_P2) begin
            r_len2 <= 67'(r_squ) + 67'(r_sqv);
        end
        if (r_state == S_P3) begin
            r_acc0 <= r_in.lin && (r_len2 < 67'(r_lim2));
            r_p_hh <= r_tol2[61:31] * r_len2[66:33];
            r_p_hl <= r_tol2[61:31] * r_len2[32:0];
            r_p_lh <= r_tol2[30:0] * r_len2[66:33];
            r_p_ll <= r_tol2[30:0] * r_len2[32:0];
        end
        if (r_state == S_P4) begin
            r_thr <= (129'(r_p_hh) << 64) + (129'(r_p_hl) << 31)
                   + (129'(r_p_lh) << 33) + 129'(r_p_ll);
        end
    end

    // Sequencer and path state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_have  <= 1'b0;
            r_cnt   <= '0;
            r_au    <= '0;
            r_av    <= '0;
            r_bad   <= 1'b0;
            r_scan  <= '0;
            r_drn   <= '0;
        end else begin
            if (w_chk_vld && w_chk_bad) begin
                r_bad <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (!r_have) begin
                            r_au   <= w_ppt.u;
                            r_av   <= w_ppt.v;
                            r_cnt  <= '0;
                            r_have <= !i_pt.path_last;
                        end else begin
                            r_state <= S_P0;
                        end
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_P4;
                S_P4: begin
                    r_bad   <= 1'b0;
                    r_scan  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == SW'(WINDOW - 1)) begin
                        r_drn   <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drn <= r_drn + 1'b1;
                    if (r_drn == 3'(pcm_pkg::DRAIN_CYC - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_cand <= r_in;
                    if (w_acc) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_cnt <= CW'(1);
                        r_au  <= w_pcand.u;
                        r_av  <= w_pcand.v;
                    end
                    if (r_last) begin
                        r_have <= 1'b0;
                        r_cnt  <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Words produced by the buffer update.
    always_comb begin
        w_res_a.tag      = r_cand.tag;
        w_res_a.x        = r_cand.x;
        w_res_a.y        = r_cand.y;
        w_res_a.z        = r_cand.z;
        w_res_a.path_end = 1'b0;
        w_res_a.run_end  = !r_last;
        w_res_b.tag      = r_in.tag;
        w_res_b.x        = r_in.x;
        w_res_b.y        = r_in.y;
        w_res_b.z        = r_in.z;
        w_res_b.path_end = 1'b1;
        w_res_b.run_end  = 1'b1;
        w_nres = w_fin ? (2'(!w_acc) + 2'(r_last)) : 2'd0;
    end

    // Output queue.
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            if (!w_acc) begin
                r_oq[r_wp] <= w_res_a;
                if (r_last) begin
                    r_oq[r_wp + 1'b1] <= w_res_b;
                end
            end else if (r_last) begin
                r_oq[r_wp] <= w_res_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_ocnt <= '0;
        end else begin
            r_wp   <= r_wp + QW'(w_nres);
            r_rp   <= r_rp + QW'(w_out_acc);
            r_ocnt <= r_ocnt + (QW + 1)'(w_nres) - (QW + 1)'(w_out_acc);
        end
    end

    assign o_kept.valid    = (r_ocnt != '0);
    assign o_kept.kept_tag = r_oq[r_rp].tag;
    assign o_kept.kept_x   = r_oq[r_rp].x;
    assign o_kept.kept_y   = r_oq[r_rp].y;
    assign o_kept.kept_z   = r_oq[r_rp].z;
    assign o_kept.path_end = r_oq[r_rp].path_end;
    assign o_kept.run_end  = r_oq[r_rp].run_end;

    // The queue never holds more words than it has slots.
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (QW + 1)'(pcm_pkg::OQ_DEPTH))
        else $error("output queue overflow");

    // A point is appended only while the buffer has room.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && w_acc) |-> (r_cnt < CW'(WINDOW)))
        else $error("append into a full buffer");

    // Checker verdicts arrive only while scanning or draining.
    a_chk_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chk_vld |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("checker verdict outside the scan window");

    // An update always returns the sequencer to idle.
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle");

endmodule

>>> verif/tb_polyline_collinear_merger_top.sv
`timescale 1ns / 1ps

module tb_polyline_collinear_merger_top;

    localparam int WIN        = 64;
    localparam int Q          = 65536;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYC = WIN + 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;

    pcm_in_if  pt_if();
    pcm_out_if kept_if();

    polyline_collinear_merger_top #(.WINDOW(WIN)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_kept     (kept_if)
    );

    // Tracks the merge state and holds the kept points still to come out.
    class kept_scoreboard;
        bit [1:0]         axis;
        bit [30:0]        tol;
        bit [30:0]        maxl;
        longint           au;
        longint           av;
        bit               have;
        int unsigned      cnt;
        pcm_pkg::t_entry  held[WIN];
        pcm_pkg::t_kept   pending[$];
        int               errors;
        int               points;
        int               kept;

        function new();
            axis = 2'd2;
            tol  = 31'd655;
            maxl = 31'h7fff_ffff;
            au = 0;
            av = 0;
            have = 0;
            cnt = 0;
            errors = 0;
            points = 0;
            kept = 0;
        endfunction

        function void configure(bit [1:0] idx, bit [30:0] d);
            case (idx)
                pcm_pkg::CFG_AXIS:   axis = d[1:0];
                pcm_pkg::CFG_TOL:    tol = d;
                pcm_pkg::CFG_MAXLEN: maxl = d;
                default: ;
            endcase
        endfunction

        // Projection onto the working plane; selector 3 behaves as 2.
        function void plane_of(pcm_pkg::t_entry e, output longint u, output longint v);
            case (axis)
                pcm_pkg::AXIS_X: begin u = $signed(e.y); v = $signed(e.z); end
                pcm_pkg::AXIS_Y: begin u = $signed(e.x); v = $signed(e.z); end
                default:         begin u = $signed(e.x); v = $signed(e.y); end
            endcase
        endfunction

        // True when a held point lies within tolerance of the candidate line.
        function bit near_line(pcm_pkg::t_entry e, longint su, longint sv, bit [255:0] len2);
            longint ku, kv, du, dv;
            logic signed [127:0] a, b, c, d, cr;
            bit [255:0] tol2, cm;
            plane_of(e, ku, kv);
            du = ku - au;
            dv = kv - av;
            tol2 = 256'(tol) * 256'(tol);
            a = du;
            b = dv;
            if (su == 0 && sv == 0)
                return (256'(a * a) + 256'(b * b)) <= tol2;
            c = sv;
            d = su;
            cr = a * c - b * d;
            if (cr < 0)
                cr = -cr;
            cm = 256'(cr);
            return (cm * cm) <= (tol2 * len2);
        endfunction

        function pcm_pkg::t_kept kept_of(pcm_pkg::t_entry e, bit pend);
            pcm_pkg::t_kept k;
            k.tag = e.tag;
            k.x = e.x;
            k.y = e.y;
            k.z = e.z;
            k.path_end = pend;
            k.run_end = 1'b0;
            return k;
        endfunction

        // Advances the merge state by one accepted point.
        function void note_point(pcm_pkg::t_entry e, bit last);
            pcm_pkg::t_kept outs[$];
            longint pu, pv, su, sv;
            bit     ok;
            bit [255:0] len2, lim;
            logic signed [127:0] a, b;
            points++;
            plane_of(e, pu, pv);
            if (!have) begin
                au = pu;
                av = pv;
                cnt = 0;
                have = !last;
                return;
            end
            if (cnt == 0) begin
                ok = 1;
            end else if (cnt >= WIN) begin
                ok = 0;
            end else begin
                su = pu - au;
                sv = pv - av;
                a = su;
                b = sv;
                len2 = 256'(a * a) + 256'(b * b);
                lim = 256'(maxl) * 256'(maxl);
                ok = e.lin && (len2 < lim);
                for (int k = 0; ok && k < cnt; k++)
                    if (!held[k].lin || !near_line(held[k], su, sv, len2))
                        ok = 0;
            end
            if (ok) begin
                held[cnt] = e;
                cnt++;
            end else begin
                outs = {outs, kept_of(held[cnt-1], 1'b0)};
                plane_of(held[cnt-1], au, av);
                held[0] = e;
                cnt = 1;
            end
            if (last) begin
                outs = {outs, kept_of(held[cnt-1], 1'b1)};
                have = 0;
                cnt = 0;
            end
            if (outs.size() > 0)
                outs[outs.size()-1].run_end = 1'b1;
            foreach (outs[i])
                pending = {pending, outs[i]};
        endfunction

        // Compares one kept word with the oldest expected one.
        function void check_kept(pcm_pkg::t_kept got);
            pcm_pkg::t_kept want;
            kept++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected kept word tag=%h x=%h y=%h z=%h",
                         $time, got.tag, got.x, got.y, got.z);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.tag !== want.tag) begin
                $display("%0t: kept_tag expected %h actual %h", $time, want.tag, got.tag);
                errors++;
            end
            if (got.x !== want.x) begin
                $display("%0t: kept_x expected %h actual %h", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: kept_y expected %h actual %h", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: kept_z expected %h actual %h", $time, want.z, got.z);
                errors++;
            end
            if (got.path_end !== want.path_end) begin
                $display("%0t: path_end expected %b actual %b", $time,
                         want.path_end, got.path_end);
                errors++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %b actual %b", $time,
                         want.run_end, got.run_end);
                errors++;
            end
        endfunction
    endclass

    kept_scoreboard sb;
    bit in_steady;
    bit out_steady;
    int stall_left;
    int idle_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output back-pressure: short stalls mostly, a few long ones.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kept_if.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            kept_if.ready <= 1'b0;
        end else if (!out_steady && $urandom_range(0, 9) < 3) begin
            stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                        : $urandom_range(10, 40);
            kept_if.ready <= 1'b0;
        end else begin
            kept_if.ready <= 1'b1;
        end
    end

    // Handshake monitor on both channels; values are the ones before the edge.
    always @(posedge i_clk) begin
        pcm_pkg::t_entry e;
        pcm_pkg::t_kept  k;
        if (i_rst_n) begin
            if (pt_if.valid && pt_if.ready) begin
                e.x = pt_if.coord_x;
                e.y = pt_if.coord_y;
                e.z = pt_if.coord_z;
                e.tag = pt_if.tag;
                e.lin = pt_if.is_linear;
                sb.note_point(e, pt_if.path_last);
            end
            if (kept_if.valid && kept_if.ready) begin
                k.tag = kept_if.kept_tag;
                k.x = kept_if.kept_x;
                k.y = kept_if.kept_y;
                k.z = kept_if.kept_z;
                k.path_end = kept_if.path_end;
                k.run_end = kept_if.run_end;
                sb.check_kept(k);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_if.valid && pt_if.ready) || (kept_if.valid && kept_if.ready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input bit lin,
                              input logic [15:0] tag, input bit last);
        int gap;
        gap = in_steady ? 0 : pick_gap();
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid     <= 1'b1;
        pt_if.coord_x   <= x;
        pt_if.coord_y   <= y;
        pt_if.coord_z   <= z;
        pt_if.is_linear <= lin;
        pt_if.tag       <= tag;
        pt_if.path_last <= last;
        do @(negedge i_clk); while (!pt_if.ready);
        @(posedge i_clk);
    endtask

    // Waits for every expected word, then lets an item without results finish.
    // First it steps past the clock edge on which the monitor notes the last point.
    task automatic settle();
        pt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_regs(input bit [1:0] ax, input bit [30:0] tl, input bit [30:0] ml);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pcm_pkg::CFG_AXIS;
        i_cfg_data <= 31'(ax);
        @(posedge i_clk);
        sb.configure(pcm_pkg::CFG_AXIS, 31'(ax));
        i_cfg_idx  <= pcm_pkg::CFG_TOL;
        i_cfg_data <= tl;
        @(posedge i_clk);
        sb.configure(pcm_pkg::CFG_TOL, tl);
        i_cfg_idx  <= pcm_pkg::CFG_MAXLEN;
        i_cfg_data <= ml;
        @(posedge i_clk);
        sb.configure(pcm_pkg::CFG_MAXLEN, ml);
        i_cfg_we   <= 1'b0;
    endtask

    // Paths of roughly straight points with noise, bends and some junk.
    task automatic run_paths(input int n);
        int sent, len, nz;
        int x, y, z, dx, dy, dz;
        bit wild;
        sent = 0;
        while (sent < n) begin
            len = $urandom_range(0, 99);
            len = (len < 4) ? $urandom_range(64, 70) :
                  (len < 10) ? 1 : $urandom_range(2, 12);
            wild = ($urandom_range(0, 9) == 0);
            nz = ($urandom_range(0, 3) == 0) ? 5000 : 300;
            if ($urandom_range(0, 4) == 0) begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end else begin
                x = int'($urandom_range(0, 2000000)) - 1000000;
                y = int'($urandom_range(0, 2000000)) - 1000000;
                z = int'($urandom_range(0, 2000000)) - 1000000;
            end
            dx = int'($urandom_range(0, 400000)) - 200000;
            dy = int'($urandom_range(0, 400000)) - 200000;
            dz = int'($urandom_range(0, 400000)) - 200000;
            for (int i = 0; i < len && sent < n; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    dx = int'($urandom_range(0, 400000)) - 200000;
                    dy = int'($urandom_range(0, 400000)) - 200000;
                end
                x += dx + int'($urandom_range(0, 2 * nz)) - nz;
                y += dy + int'($urandom_range(0, 2 * nz)) - nz;
                z += dz + int'($urandom_range(0, 2 * nz)) - nz;
                if (wild)
                    send_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                               16'($urandom), i == len - 1);
                else
                    send_point(x, y, z, $urandom_range(0, 19) != 0, 16'($urandom),
                               i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        bit [1:0]  ax[8];
        bit [30:0] tl[8];
        bit [30:0] ml[8];
        sb = new();
        in_steady = 0;
        out_steady = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= pcm_pkg::CFG_AXIS;
        i_cfg_data <= '0;
        pt_if.valid <= 1'b0;
        pt_if.coord_x <= '0;
        pt_if.coord_y <= '0;
        pt_if.coord_z <= '0;
        pt_if.is_linear <= 1'b0;
        pt_if.tag <= '0;
        pt_if.path_last <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under reset settings: single point, straight run,
        // arc move, off-line point, zero-length line and coordinate extremes.
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 16'hffff, 1);
        send_point(0, 0, 0, 1, 16'd1, 0);
        send_point(Q, 0, 7, 1, 16'd2, 0);
        send_point(2 * Q, 0, 0, 1, 16'd3, 0);
        send_point(3 * Q, 0, 0, 1, 16'd4, 0);
        send_point(4 * Q, 0, 0, 0, 16'd5, 0);
        send_point(5 * Q, 0, 0, 1, 16'd6, 0);
        send_point(5 * Q, 3 * Q, 0, 1, 16'd7, 0);
        send_point(5 * Q, 0, 0, 1, 16'd8, 0);
        send_point(5 * Q, 200, 0, 1, 16'd9, 0);
        send_point(5 * Q, 0, 0, 1, 16'd10, 1);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 16'h0000, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 16'h8000, 0);
        send_point(0, 0, 0, 1, 16'h00ff, 0);
        send_point(32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 1, 16'haaaa, 1);
        settle();

        ax = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd2, 2'd1, 2'd0, 2'd2};
        tl = '{31'd0, 31'h7fff_ffff, 31'd5000, 31'd655, 31'd1000, 31'd300, 31'd2000,
               31'd655};
        ml = '{31'h7fff_ffff, 31'd0, 31'(20 * Q), 31'h7fff_ffff, 31'(3 * Q),
               31'(200 * Q), 31'(8 * Q), 31'h7fff_ffff};
        ax[6] = 2'($urandom_range(0, 3));
        tl[6] = 31'($urandom_range(0, 20000));
        ml[6] = 31'($urandom_range(Q, 100 * Q));

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < 8; ph++) begin
            in_steady = (ph % 3 == 1);
            out_steady = (ph % 4 == 2);
            write_regs(ax[ph], tl[ph], ml[ph]);
            run_paths(235);
            settle();
        end

        $display("Covered %0d points and %0d kept words over 8 register settings,",
                 sb.points, sb.kept);
        $display("including full buffers, arc moves and plane changes inside paths.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
